FILE: src/sawtc_pkg.sv
// ----------------------------------------------------------------------------
// sawtc_pkg: shared definitions for the set-associative write-through cache
// Default geometry, item and result codes, and the controller states.
// ----------------------------------------------------------------------------
package sawtc_pkg;

  // Default geometry
  localparam int unsigned WORD_OFFSET_BITS_DEF = 3;
  localparam int unsigned SET_INDEX_BITS_DEF   = 6;
  localparam int unsigned WAY_INDEX_BITS_DEF   = 1;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned BYTE_OFF_BITS = 2;

  // Item codes
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FILL  = 2'd2
  } mode_e;

  // Result codes
  typedef enum logic [1:0] {
    KIND_READ_DATA     = 2'd0,
    KIND_MEM_READ      = 2'd1,
    KIND_WRITE_THROUGH = 2'd2
  } kind_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_REQ,
    ST_FINISH,
    ST_RESP
  } state_e;

endpackage

FILE: src/sawtc_way_ram.sv
// ----------------------------------------------------------------------------
// sawtc_way_ram: way-wide synchronous RAM
// One row holds an entry per way; writes are masked per way, reads return the
// whole row from a register in the next cycle.
// ----------------------------------------------------------------------------
module sawtc_way_ram #(
  parameter  int unsigned ROW_BITS = 6,
  parameter  int unsigned WAYS     = 2,
  parameter  int unsigned ENTRY_W  = 32,
  localparam int unsigned ROWS     = 1 << ROW_BITS,
  localparam int unsigned AW       = (ROW_BITS > 0) ? ROW_BITS : 1
) (
  input  logic                          clk_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [WAYS-1:0]               wmask_i,
  input  logic [ENTRY_W-1:0]            wdata_i,
  output logic [WAYS-1:0][ENTRY_W-1:0]  rdata_o
);

  logic [WAYS-1:0][ENTRY_W-1:0] mem_q [ROWS];
  logic [WAYS-1:0][ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int w = 0; w < WAYS; w++) begin
        if (wmask_i[w]) begin
          mem_q[waddr_i][w] <= wdata_i;
        end
      end
    end
    // hold the last row read while idle
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/sawtc_tag_match.sv
// ----------------------------------------------------------------------------
// sawtc_tag_match: parallel tag compare
// Compares a tag against every valid way of a set; the lowest match wins.
// ----------------------------------------------------------------------------
module sawtc_tag_match #(
  parameter  int unsigned WAYS  = 2,
  parameter  int unsigned TAG_W = 21,
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [WAYS-1:0][TAG_W:0] entry_i,   // {valid, tag} per way
  input  logic [TAG_W-1:0]         tag_i,
  output logic                     hit_o,
  output logic [WAY_W-1:0]         way_o
);

  always_comb begin
    hit_o = 1'b0;
    way_o = '0;
    // scan downwards so the lowest matching way is kept
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (entry_i[w][TAG_W] && (entry_i[w][TAG_W-1:0] == tag_i)) begin
        hit_o = 1'b1;
        way_o = WAY_W'(w);
      end
    end
  end

endmodule

FILE: src/set_assoc_write_through_cache_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_write_through_cache_unit: set-associative write-through cache
// Hit: result in the cycle after the transfer, read from the registered
//   tag and data RAMs; busy is high meanwhile, so accesses never overlap.
// Miss: the lookup state, then one memory read request a cycle for a line.
// Refill words: one a cycle; after the last, the answer comes from the finish
//   state (write) or the response state after it (read, re-reading data RAM).
// Reset: a clearing pass walks the tag RAM one set a cycle over all sets,
//   2**SET_INDEX_BITS, busy high. Results are strobed and cannot be stalled.
// ----------------------------------------------------------------------------
module set_assoc_write_through_cache_unit
  import sawtc_pkg::*;
#(
  parameter int unsigned WORD_OFFSET_BITS = WORD_OFFSET_BITS_DEF,
  parameter int unsigned SET_INDEX_BITS   = SET_INDEX_BITS_DEF,
  parameter int unsigned WAY_INDEX_BITS   = WAY_INDEX_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] fill_data_i,
  output logic        res_valid_o,
  output logic [1:0]  kind_o,
  output logic [31:0] out_address_o,
  output logic [31:0] out_data_o,
  output logic        hit_o,
  output logic        last_o
);

  localparam int unsigned NWORDS    = 1 << WORD_OFFSET_BITS;
  localparam int unsigned NSETS     = 1 << SET_INDEX_BITS;
  localparam int unsigned NWAYS     = 1 << WAY_INDEX_BITS;
  localparam int unsigned WORD_SH   = BYTE_OFF_BITS;
  localparam int unsigned SET_SH    = WORD_OFFSET_BITS + BYTE_OFF_BITS;
  localparam int unsigned TAG_SHIFT = WORD_OFFSET_BITS + SET_INDEX_BITS + BYTE_OFF_BITS;
  localparam int unsigned TAG_W     = DATA_W - TAG_SHIFT;
  localparam int unsigned SET_W     = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
  localparam int unsigned WRD_W     = (WORD_OFFSET_BITS > 0) ? WORD_OFFSET_BITS : 1;
  localparam int unsigned WAY_W     = (WAY_INDEX_BITS > 0) ? WAY_INDEX_BITS : 1;
  localparam int unsigned ROW_BITS  = SET_INDEX_BITS + WORD_OFFSET_BITS;
  localparam int unsigned ROW_W     = (ROW_BITS > 0) ? ROW_BITS : 1;
  localparam int unsigned LINE_MASK = (NWORDS << BYTE_OFF_BITS) - 1;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [SET_W-1:0]  clr_q, clr_d;        // clearing pass pointer
  logic [WRD_W-1:0]  cnt_q, cnt_d;        // request / refill word counter
  logic              pend_q, pend_d;      // line refill outstanding
  logic [WAY_W-1:0]  victim_q, victim_d;  // round-robin replacement pointer
  logic [31:0]       addr_q;              // access under way (also refill target)
  logic [31:0]       wdata_q;
  logic              wr_q;                // access is a write
  logic              latch;

  // --------------------------------------------------------------------------
  // Address split
  // --------------------------------------------------------------------------
  logic [SET_W-1:0] in_set, p_set;
  logic [WRD_W-1:0] in_word, p_word;
  logic [TAG_W-1:0] p_tag;
  logic [ROW_W-1:0] in_row, p_row, fill_row;
  logic [31:0]      line_base;

  assign in_set  = SET_W'((address_i >> SET_SH) & (NSETS - 1));
  assign in_word = WRD_W'((address_i >> WORD_SH) & (NWORDS - 1));
  assign p_set   = SET_W'((addr_q >> SET_SH) & (NSETS - 1));
  assign p_word  = WRD_W'((addr_q >> WORD_SH) & (NWORDS - 1));
  assign p_tag   = TAG_W'(addr_q >> TAG_SHIFT);

  assign in_row   = ROW_W'((32'(in_set) << WORD_OFFSET_BITS)
                           | (32'(in_word) & (NWORDS - 1)));
  assign p_row    = ROW_W'((32'(p_set) << WORD_OFFSET_BITS)
                           | (32'(p_word) & (NWORDS - 1)));
  assign fill_row = ROW_W'((32'(p_set) << WORD_OFFSET_BITS)
                           | (32'(cnt_q) & (NWORDS - 1)));

  // refill requests go out on the word-aligned line base
  assign line_base = addr_q & ~32'(LINE_MASK);

  // --------------------------------------------------------------------------
  // Tag RAM: {valid, tag} per way, one row per set
  // --------------------------------------------------------------------------
  logic                        tag_re, tag_we;
  logic [SET_W-1:0]            tag_waddr;
  logic [NWAYS-1:0]            tag_wmask;
  logic [TAG_W:0]              tag_wdata;
  logic [NWAYS-1:0][TAG_W:0]   tag_rdata;

  sawtc_way_ram #(
    .ROW_BITS (SET_INDEX_BITS),
    .WAYS     (NWAYS),
    .ENTRY_W  (TAG_W + 1)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .re_i    (tag_re),
    .raddr_i (in_set),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wmask_i (tag_wmask),
    .wdata_i (tag_wdata),
    .rdata_o (tag_rdata)
  );

  // --------------------------------------------------------------------------
  // Data RAM: one word per way, one row per (set, word)
  // --------------------------------------------------------------------------
  logic                         data_re, data_we;
  logic [ROW_W-1:0]             data_raddr, data_waddr;
  logic [NWAYS-1:0]             data_wmask;
  logic [31:0]                  data_wdata;
  logic [NWAYS-1:0][31:0]       data_rdata;

  sawtc_way_ram #(
    .ROW_BITS (ROW_BITS),
    .WAYS     (NWAYS),
    .ENTRY_W  (DATA_W)
  ) u_data_ram (
    .clk_i   (clk_i),
    .re_i    (data_re),
    .raddr_i (data_raddr),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wmask_i (data_wmask),
    .wdata_i (data_wdata),
    .rdata_o (data_rdata)
  );

  // --------------------------------------------------------------------------
  // Tag compare on the row read at the transfer
  // --------------------------------------------------------------------------
  logic             hit;
  logic [WAY_W-1:0] hit_way;

  sawtc_tag_match #(
    .WAYS  (NWAYS),
    .TAG_W (TAG_W)
  ) u_tag_match (
    .entry_i (tag_rdata),
    .tag_i   (p_tag),
    .hit_o   (hit),
    .way_o   (hit_way)
  );

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  logic             accept;
  logic             cnt_last;
  logic [WAY_W-1:0] victim_next;
  logic [NWAYS-1:0] victim_mask;
  kind_e            kind;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cnt_last    = (cnt_q == WRD_W'(NWORDS - 1));
  assign victim_next = WAY_W'((32'(victim_q) + 1) & (NWAYS - 1));
  assign victim_mask = NWAYS'(1) << victim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      victim_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      victim_q <= victim_d;
    end
  end

  // access payload: captured only when an access goes to lookup
  always_ff @(posedge clk_i) begin
    if (latch) begin
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      wr_q    <= (mode_i == MODE_WRITE);
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    victim_d   = victim_q;
    latch      = 1'b0;

    tag_re     = 1'b0;
    tag_we     = 1'b0;
    tag_waddr  = p_set;
    tag_wmask  = victim_mask;
    tag_wdata  = '0;

    data_re    = 1'b0;
    data_raddr = in_row;
    data_we    = 1'b0;
    data_waddr = p_row;
    data_wmask = victim_mask;
    data_wdata = wdata_q;

    res_valid_o   = 1'b0;
    kind          = KIND_READ_DATA;
    out_address_o = addr_q;
    out_data_o    = '0;
    hit_o         = 1'b0;
    last_o        = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // invalidate every way of one set per cycle
        tag_we    = 1'b1;
        tag_waddr = clr_q;
        tag_wmask = '1;
        if (clr_q == SET_W'(NSETS - 1)) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          case (mode_i) inside
            MODE_READ, MODE_WRITE: begin
              // drop accesses while a refill is outstanding
              if (!pend_q) begin
                latch   = 1'b1;
                tag_re  = 1'b1;
                data_re = 1'b1;
                state_d = ST_LOOKUP;
              end
            end
            MODE_FILL: begin
              // drop stray refill words
              if (pend_q) begin
                data_we    = 1'b1;
                data_waddr = fill_row;
                data_wdata = fill_data_i;
                if (cnt_last) begin
                  tag_we    = 1'b1;
                  tag_wdata = {1'b1, p_tag};
                  pend_d    = 1'b0;
                  cnt_d     = '0;
                  state_d   = ST_FINISH;
                end else begin
                  cnt_d = cnt_q + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_LOOKUP: begin
        if (hit) begin
          res_valid_o = 1'b1;
          hit_o       = 1'b1;
          last_o      = 1'b1;
          if (wr_q) begin
            data_we    = 1'b1;
            data_wmask = NWAYS'(1) << hit_way;
            kind       = KIND_WRITE_THROUGH;
            out_data_o = wdata_q;
          end else begin
            kind       = KIND_READ_DATA;
            out_data_o = data_rdata[hit_way];
          end
          state_d = ST_IDLE;
        end else begin
          // miss: invalidate the victim line and start the request run
          tag_we  = 1'b1;
          cnt_d   = '0;
          state_d = ST_REQ;
        end
      end

      ST_REQ: begin
        res_valid_o   = 1'b1;
        kind          = KIND_MEM_READ;
        out_address_o = line_base + (32'(cnt_q) << BYTE_OFF_BITS);
        last_o        = cnt_last;
        if (cnt_last) begin
          cnt_d   = '0;
          pend_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_FINISH: begin
        if (wr_q) begin
          // merge the held write into the fresh line and write it through
          data_we     = 1'b1;
          res_valid_o = 1'b1;
          kind        = KIND_WRITE_THROUGH;
          out_data_o  = wdata_q;
          last_o      = 1'b1;
          victim_d    = victim_next;
          state_d     = ST_IDLE;
        end else begin
          data_re    = 1'b1;
          data_raddr = p_row;
          state_d    = ST_RESP;
        end
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        kind        = KIND_READ_DATA;
        out_data_o  = data_rdata[victim_q];
        last_o      = 1'b1;
        victim_d    = victim_next;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign kind_o = kind;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result strobe while idle");

  a_run_end_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && kind_o == KIND_MEM_READ && last_o) |=> pend_q)
    else $error("request run ended without a pending refill");

  a_no_hit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !(res_valid_o && hit_o))
    else $error("hit reported while a refill is pending");

  a_victim_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !hit_o && kind_o != KIND_MEM_READ)
      |=> victim_q == WAY_W'((32'($past(victim_q)) + 1) & (NWAYS - 1)))
    else $error("victim pointer did not advance after a refill");

endmodule

FILE: tb/sawtc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawtc_result_checker: result checker for the write-through cache unit
// Watches the item and result channels, keeps its own copy of the tags,
// valid bits, line data and refill progress, and checks each strobed result
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sawtc_result_checker
  import sawtc_pkg::*;
#(
  parameter int unsigned WORD_OFFSET_BITS = WORD_OFFSET_BITS_DEF,
  parameter int unsigned SET_INDEX_BITS   = SET_INDEX_BITS_DEF,
  parameter int unsigned WAY_INDEX_BITS   = WAY_INDEX_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  mode_i,
  input  logic [31:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] fill_data_i,
  input  logic        res_valid_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] out_address_i,
  input  logic [31:0] out_data_i,
  input  logic        hit_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  localparam int unsigned NWORDS    = 1 << WORD_OFFSET_BITS;
  localparam int unsigned NSETS     = 1 << SET_INDEX_BITS;
  localparam int unsigned NWAYS     = 1 << WAY_INDEX_BITS;
  localparam int unsigned NLINES    = NWAYS * NSETS;
  localparam int unsigned TAG_SHIFT = WORD_OFFSET_BITS + SET_INDEX_BITS + BYTE_OFF_BITS;
  localparam int unsigned TAG_W     = DATA_W - TAG_SHIFT;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        hit;
    logic        last;
  } cache_result_t;

  logic [TAG_W-1:0] tag_mem    [NLINES];
  logic             line_valid [NLINES];
  logic [31:0]      word_mem   [NLINES * NWORDS];
  int unsigned      victim_way;
  logic             refill_active;
  int unsigned      refill_word;
  logic             refill_is_write;
  logic [31:0]      refill_addr;
  logic [31:0]      refill_wdata;

  cache_result_t    due_results [$];
  cache_result_t    oldest;
  int unsigned      fails = 0;

  function automatic int unsigned set_of(input logic [31:0] a);
    return (a >> (WORD_OFFSET_BITS + BYTE_OFF_BITS)) & (NSETS - 1);
  endfunction

  function automatic int unsigned word_of(input logic [31:0] a);
    return (a >> BYTE_OFF_BITS) & (NWORDS - 1);
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a);
    return TAG_W'(a >> TAG_SHIFT);
  endfunction

  function automatic void queue_result(input kind_e kind, input logic [31:0] addr,
                                       input logic [31:0] data, input logic hit,
                                       input logic last);
    due_results.push_back('{kind, addr, data, hit, last});
  endfunction

  // Advance the cache copy by one accepted item and queue what it causes
  task automatic step_cache(input logic [1:0] op, input logic [31:0] addr,
                            input logic [31:0] wdata, input logic [31:0] fdata);
    int unsigned set_idx;
    int unsigned line;
    int unsigned w;
    int unsigned way;
    int unsigned k;
    bit          found;
    logic [31:0] base;
    case (op)
      MODE_FILL: begin
        if (refill_active) begin
          line = victim_way * NSETS + set_of(refill_addr);
          word_mem[line * NWORDS + refill_word] = fdata;
          if (refill_word != NWORDS - 1) begin
            refill_word++;
          end else begin
            refill_active    = 1'b0;
            refill_word      = 0;
            tag_mem[line]    = tag_of(refill_addr);
            line_valid[line] = 1'b1;
            victim_way       = (victim_way + 1) % NWAYS;
            w = line * NWORDS + word_of(refill_addr);
            if (refill_is_write) begin
              word_mem[w] = refill_wdata;
              queue_result(KIND_WRITE_THROUGH, refill_addr, refill_wdata, 1'b0, 1'b1);
            end else begin
              queue_result(KIND_READ_DATA, refill_addr, word_mem[w], 1'b0, 1'b1);
            end
          end
        end
      end
      MODE_READ, MODE_WRITE: begin
        if (!refill_active) begin
          set_idx = set_of(addr);
          found   = 1'b0;
          for (way = 0; way < NWAYS && !found; way++) begin
            line = way * NSETS + set_idx;
            if (line_valid[line] && tag_mem[line] == tag_of(addr)) begin
              found = 1'b1;
              w = line * NWORDS + word_of(addr);
              if (op == MODE_WRITE) begin
                word_mem[w] = wdata;
                queue_result(KIND_WRITE_THROUGH, addr, wdata, 1'b1, 1'b1);
              end else begin
                queue_result(KIND_READ_DATA, addr, word_mem[w], 1'b1, 1'b1);
              end
            end
          end
          if (!found) begin
            // Victim line drops out now and comes back with the last refill word
            line             = victim_way * NSETS + set_idx;
            line_valid[line] = 1'b0;
            refill_active    = 1'b1;
            refill_word      = 0;
            refill_is_write  = (op == MODE_WRITE);
            refill_addr      = addr;
            refill_wdata     = (op == MODE_WRITE) ? wdata : 32'd0;
            base = addr & ~(32'(NWORDS * 4) - 32'd1);
            for (k = 0; k < NWORDS; k++) begin
              queue_result(KIND_MEM_READ, base + 32'(4 * k), 32'd0, 1'b0, k == NWORDS - 1);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NLINES; i++) begin
        tag_mem[i]    = '0;
        line_valid[i] = 1'b0;
      end
      victim_way      = 0;
      refill_active   = 1'b0;
      refill_word     = 0;
      refill_is_write = 1'b0;
      refill_addr     = '0;
      refill_wdata    = '0;
      due_results.delete();
      fail_count_o  <= fails;
      outstanding_o <= 0;
    end else begin
      // A result always belongs to an earlier transfer, so check before predicting
      if (res_valid_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d address 0x%0h data 0x%0h",
                 kind_i, out_address_i, out_data_i);
          fails++;
        end else begin
          oldest = due_results.pop_front();
          check_field("kind", 32'(oldest.kind), 32'(kind_i));
          check_field("out_address", oldest.addr, out_address_i);
          check_field("out_data", oldest.data, out_data_i);
          check_field("hit", 32'(oldest.hit), 32'(hit_i));
          check_field("last", 32'(oldest.last), 32'(last_i));
        end
      end
      if (start_i && !busy_i) begin
        step_cache(mode_i, address_i, write_data_i, fill_data_i);
      end
      fail_count_o  <= fails;
      outstanding_o <= due_results.size();
    end
  end

endmodule

FILE: tb/tb_set_assoc_write_through_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_write_through_cache_unit: testbench for the write-through cache
// Drives read, write and refill items through the start/busy handshake, runs
// each miss through its full refill, sprinkles in ignored items, and leaves
// prediction and checking of the strobed results to the checker beside it.
// ----------------------------------------------------------------------------
module tb_set_assoc_write_through_cache_unit;
  import sawtc_pkg::*;

  localparam int unsigned WOB            = WORD_OFFSET_BITS_DEF;
  localparam int unsigned SIB            = SET_INDEX_BITS_DEF;
  localparam int unsigned NWORDS         = 1 << WOB;
  localparam int unsigned TAG_W          = DATA_W - WOB - SIB - BYTE_OFF_BITS;
  localparam int unsigned ITEM_TARGET    = 150;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  // Mode code that the block has no use for; it must be dropped silently
  localparam logic [1:0]  MODE_UNUSED    = 2'b11;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic        busy;
  logic [1:0]  mode_i        = MODE_READ;
  logic [31:0] address_i     = '0;
  logic [31:0] write_data_i  = '0;
  logic [31:0] fill_data_i   = '0;
  logic        res_valid_o;
  logic [1:0]  kind_o;
  logic [31:0] out_address_o;
  logic [31:0] out_data_o;
  logic        hit_o;
  logic        last_o;

  int unsigned fail_count;
  int unsigned outstanding;

  // Stimulus bookkeeping, derived from what the block hands back
  int unsigned last_count   = 0;
  logic        refill_open  = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned useful_items = 0;
  int unsigned idle_pct     = 0;
  int unsigned idle_plan [3] = '{0, 47, 30};

  // A few tags and sets get most of the traffic so that lines hit and evict
  logic [TAG_W-1:0] tag_pool [3];
  logic [SIB-1:0]   set_pool [2];

  set_assoc_write_through_cache_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .fill_data_i   (fill_data_i),
    .res_valid_o   (res_valid_o),
    .kind_o        (kind_o),
    .out_address_o (out_address_o),
    .out_data_o    (out_data_o),
    .hit_o         (hit_o),
    .last_o        (last_o)
  );

  sawtc_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .mode_i        (mode_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .fill_data_i   (fill_data_i),
    .res_valid_i   (res_valid_o),
    .kind_i        (kind_o),
    .out_address_i (out_address_o),
    .out_data_i    (out_data_o),
    .hit_i         (hit_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Count the closing result of each run. A final memory read request opens a
  // refill; a closing miss answer (not a request, no hit) shuts it again.
  always @(posedge clk_i) begin
    if (res_valid_o && last_o) begin
      last_count <= last_count + 1;
      if (kind_o == KIND_MEM_READ) begin
        refill_open <= 1'b1;
      end else if (!hit_o) begin
        refill_open <= 1'b0;
      end
    end
  end

  // Watchdog: give up when neither channel has moved for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Random address: mostly pooled tag and set, word and byte offset always free
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(9) < 8) begin
      a[31 -: TAG_W] = tag_pool[$urandom_range(2)];
    end
    if ($urandom_range(9) < 8) begin
      a[BYTE_OFF_BITS + WOB +: SIB] = set_pool[$urandom_range(1)];
    end
    return a;
  endfunction

  // Present one item and hold it until the block takes it. Start is left
  // high so that a following item can go out back to back; callers that
  // then wait on results drop it themselves.
  task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                           input logic [31:0] wdata, input logic [31:0] fdata);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    mode_i       <= op;
    address_i    <= addr;
    write_data_i <= wdata;
    fill_data_i  <= fdata;
    do @(posedge clk_i); while (busy);
  endtask

  // One access, and when it misses, the whole refill that it asks for.
  // noisy_at picks a refill word before which a stray access is slipped in;
  // flat_fill alternates all-zero and all-one refill words.
  task automatic run_access(input logic [1:0] op, input logic [31:0] addr,
                            input logic [31:0] wdata, input int noisy_at,
                            input bit flat_fill);
    int unsigned snap;
    int          i;
    snap = last_count;
    send_item(op, addr, wdata, $urandom);
    start <= 1'b0;
    useful_items++;
    while (last_count == snap) @(posedge clk_i);
    if (refill_open) begin
      for (i = 0; i < NWORDS; i++) begin
        // Access during refill: taken by the handshake but ignored
        if (i == noisy_at) begin
          send_item($urandom_range(1) ? MODE_WRITE : MODE_READ, pick_address(),
                    $urandom, $urandom);
        end
        send_item(MODE_FILL, $urandom, $urandom, flat_fill ? {32{i[0]}} : $urandom);
        useful_items++;
      end
      start <= 1'b0;
      while (last_count == snap + 1) @(posedge clk_i);
    end
  endtask

  initial begin
    foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
    foreach (set_pool[i]) set_pool[i] = SIB'($urandom);

    // Hold reset, then release it; the clearing pass then shows up as busy
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty-cache read miss with extreme refill words, a hit
    // on the last word with an unaligned address, write hit and read back,
    // an all-ones write miss with an access during the refill, a stray
    // refill word and the unused mode.
    run_access(MODE_READ, 32'h0000_0000, 32'h0000_0000, -1, 1'b1);
    run_access(MODE_READ, 32'h0000_001F, 32'h0000_0000, -1, 1'b0);
    run_access(MODE_WRITE, 32'h0000_0008, 32'hFFFF_FFFF, -1, 1'b0);
    run_access(MODE_READ, 32'h0000_0008, 32'h0000_0000, -1, 1'b0);
    run_access(MODE_WRITE, 32'hFFFF_FFFF, 32'h0000_0000, 3, 1'b1);
    send_item(MODE_FILL, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);

    // Random part: well-formed accesses with their refills, and now and then
    // an item the block must drop. Walk the idling plan as items go by.
    while (useful_items < ITEM_TARGET) begin
      idle_pct = idle_plan[(useful_items * 3) / ITEM_TARGET];
      if ($urandom_range(99) < 8) begin
        send_item($urandom_range(1) ? MODE_UNUSED : MODE_FILL, pick_address(),
                  $urandom, $urandom);
      end else begin
        run_access($urandom_range(1) ? MODE_WRITE : MODE_READ, pick_address(), $urandom,
                   ($urandom_range(9) == 0) ? int'($urandom_range(NWORDS - 1)) : -1,
                   1'b0);
      end
    end
    start <= 1'b0;

    // Drain: wait out every prediction, then keep watching for stray results
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
